// File: design/tdf_pkg.sv
// Shared constants for the trial-division prime factorizer.
// No dependencies; used by trial_division_factorizer.
`default_nettype none

package tdf_pkg;

  // Default width of the integer to factor
  localparam int unsigned VALUE_WIDTH_DEF = 32;
  // Fixed width of the factor field on the result channel
  localparam int unsigned FACTOR_WIDTH    = 32;
  // Smallest trial divisor
  localparam int unsigned FIRST_CAND      = 2;

endpackage

`default_nettype wire

// File: design/trial_division_factorizer.sv
// Trial-division prime factorizer, top level.
// Depends on tdf_pkg for widths and the first trial divisor.
// Usage:
//   Slave channel s_axis_* carries one unsigned integer per item. Master
//   channel m_axis_* returns its prime factors in non-decreasing order, with
//   repeats, one item per factor; tlast marks the final factor. Inputs 0 and
//   1 give no result items.
// Operation:
//   Each trial division runs through a bit-serial restoring divider, one
//   quotient bit per cycle, then the decision cycle. An item needs one
//   trial division per candidate tried from 2 up to the square root of the
//   shrinking remainder, plus one per factor divided out. The divider is
//   the single shared unit; one item is worked on at a time.
//   Values 0 and 1 are taken and dropped.
// Reset and stall:
//   Reset returns the block to idle with the output register empty. The
//   result sits in an output register; when the receiver stalls, the block
//   holds at its decision cycle until the register frees up. A new item is
//   accepted as soon as the last factor is registered, even while it still
//   waits to be taken.
`default_nettype none

module trial_division_factorizer #(
  parameter int unsigned VALUE_WIDTH = tdf_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  wire logic [((VALUE_WIDTH+7)/8)*8-1:0]    s_axis_tdata,   // [W-1:0] value
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  output logic [tdf_pkg::FACTOR_WIDTH-1:0]         m_axis_tdata,   // [31:0] factor
  output logic                                     m_axis_tlast    // last factor
);

  localparam int unsigned W    = VALUE_WIDTH;
  localparam int unsigned CntW = $clog2(VALUE_WIDTH);
  localparam int unsigned FW   = tdf_pkg::FACTOR_WIDTH;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EVAL
  } state_e;

  state_e          state_q, state_d;
  logic [W-1:0]    rem_q, rem_d;     // remaining value
  logic [W-1:0]    cand_q, cand_d;   // trial divisor
  logic [W-1:0]    quo_q, quo_d;     // dividend shifting out, quotient shifting in
  logic [W-1:0]    prem_q, prem_d;   // partial remainder
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            ovalid_q, ovalid_d;
  logic [FW-1:0]   ofactor_q, ofactor_d;
  logic            olast_q, olast_d;

  logic [W:0]      trial;
  logic            ge;
  logic [W-1:0]    in_value;
  logic            slot_free;

  assign in_value  = s_axis_tdata[W-1:0];
  assign slot_free = !ovalid_q || m_axis_tready;
  assign trial     = {prem_q, quo_q[W-1]};
  assign ge        = trial >= {1'b0, cand_q};

  always_comb begin
    state_d   = state_q;
    rem_d     = rem_q;
    cand_d    = cand_q;
    quo_d     = quo_q;
    prem_d    = prem_q;
    cnt_d     = cnt_q;
    ovalid_d  = ovalid_q && !m_axis_tready;
    ofactor_d = ofactor_q;
    olast_d   = olast_q;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid && in_value >= W'(tdf_pkg::FIRST_CAND)) begin
          rem_d   = in_value;
          cand_d  = W'(tdf_pkg::FIRST_CAND);
          quo_d   = in_value;
          prem_d  = '0;
          cnt_d   = CntW'(W - 1);
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        // one restoring step per cycle
        prem_d = ge ? W'(trial - {1'b0, cand_q}) : W'(trial);
        quo_d  = {quo_q[W-2:0], ge};
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (cand_q > quo_q) begin
          // candidate squared exceeds remainder: remainder is prime
          if (slot_free) begin
            ovalid_d  = 1'b1;
            ofactor_d = FW'(rem_q);
            olast_d   = 1'b1;
            state_d   = ST_IDLE;
          end
        end else if (prem_q == '0) begin
          if (slot_free) begin
            ovalid_d  = 1'b1;
            ofactor_d = FW'(cand_q);
            olast_d   = 1'b0;
            rem_d     = quo_q;
            quo_d     = quo_q;
            prem_d    = '0;
            cnt_d     = CntW'(W - 1);
            state_d   = ST_DIV;
          end
        end else begin
          cand_d  = cand_q + 1'b1;
          quo_d   = rem_q;
          prem_d  = '0;
          cnt_d   = CntW'(W - 1);
          state_d = ST_DIV;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rem_q     <= '0;
      cand_q    <= '0;
      quo_q     <= '0;
      prem_q    <= '0;
      cnt_q     <= '0;
      ovalid_q  <= 1'b0;
      ofactor_q <= '0;
      olast_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      rem_q     <= rem_d;
      cand_q    <= cand_d;
      quo_q     <= quo_d;
      prem_q    <= prem_d;
      cnt_q     <= cnt_d;
      ovalid_q  <= ovalid_d;
      ofactor_q <= ofactor_d;
      olast_q   <= olast_d;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = ofactor_q;
  assign m_axis_tlast  = olast_q;

  // While busy, both the remainder and the candidate stay at two or more
  a_busy_operands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (rem_q >= W'(2) && cand_q >= W'(2)))
    else $error("busy with remainder or candidate below two");

  // The divider hands over to the decision cycle after its last bit
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && cnt_q == '0) |=> (state_q == ST_EVAL))
    else $error("divider did not finish on its last bit");

  // A finished division leaves a remainder below the divisor
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL) |-> (prem_q < cand_q))
    else $error("division remainder not below divisor");

endmodule

`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for trial_division_factorizer.
// Predicts the prime factors of every accepted value and checks the factor stream.
// Depends on tdf_pkg and the RTL only.
`timescale 1ns / 100ps

module testbench;

  typedef struct packed {
    logic [tdf_pkg::FACTOR_WIDTH-1:0] factor;
    logic                             last;
  } factor_t;

  localparam int unsigned ITEMS_PER_PHASE = 44;
  localparam int unsigned DRAIN_CYCLES    = 100;
  localparam int unsigned SQUEEZE_CYCLES  = 3000;

  logic                                clk      = 1'b0;
  logic                                rst_n    = 1'b0;
  logic                                s_tvalid = 1'b0;
  logic                                s_tready;
  logic [tdf_pkg::VALUE_WIDTH_DEF-1:0] s_tdata  = '0;
  logic                                m_tvalid;
  logic                                m_tready = 1'b0;
  logic [tdf_pkg::FACTOR_WIDTH-1:0]    m_tdata;
  logic                                m_tlast;

  logic                                hold_off       = 1'b0;
  int unsigned                         send_idle_pct  = 0;
  int unsigned                         recv_stall_pct = 0;
  int unsigned                         fail_count     = 0;

  logic [tdf_pkg::VALUE_WIDTH_DEF-1:0] pending_values[$];
  factor_t                             expected_factors[$];
  factor_t                             want;

  trial_division_factorizer dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tlast  (m_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  // Trial division; a factor is held back one step so the final one gets last set
  function automatic void predict_factors(input logic [tdf_pkg::VALUE_WIDTH_DEF-1:0] value);
    longint unsigned rem;
    longint unsigned cand;
    factor_t         held;
    bit              have_held;
    rem       = 64'(value);
    cand      = 64'(tdf_pkg::FIRST_CAND);
    have_held = 1'b0;
    held      = '0;
    if (rem < 2) return;
    while (cand <= rem / cand) begin
      if (rem % cand == 0) begin
        rem = rem / cand;
        if (have_held) expected_factors.push_back(held);
        held.factor = cand[tdf_pkg::FACTOR_WIDTH-1:0];
        held.last   = 1'b0;
        have_held   = 1'b1;
      end else begin
        cand++;
      end
    end
    if (rem > 1) begin
      if (have_held) expected_factors.push_back(held);
      held.factor = rem[tdf_pkg::FACTOR_WIDTH-1:0];
      have_held   = 1'b1;
    end
    held.last = 1'b1;
    expected_factors.push_back(held);
  endfunction

  // Mostly products of small factors: wide values, many repeats, short runtimes
  function automatic logic [tdf_pkg::VALUE_WIDTH_DEF-1:0] random_value();
    longint unsigned prod;
    longint unsigned f;
    int unsigned     kind;
    int unsigned     n;
    kind = $urandom_range(0, 99);
    if (kind < 5) return $urandom_range(0, 1);
    if (kind < 15) return $urandom_range(2, 4095);
    prod = 1;
    n    = $urandom_range(1, 31);
    for (int i = 0; i < n; i++) begin
      f = 64'(($urandom_range(0, 2) == 0) ? $urandom_range(2, 3) : $urandom_range(2, 47));
      if (prod * f > 64'hFFFF_FFFF) break;
      prod = prod * f;
    end
    f = 64'($urandom_range(1, 1 << $urandom_range(1, 12)));
    if (prod * f <= 64'hFFFF_FFFF) prod = prod * f;
    return prod[tdf_pkg::VALUE_WIDTH_DEF-1:0];
  endfunction

  // Sender: holds an item until it is taken, then maybe idles
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else begin
      if (s_tvalid && s_tready) predict_factors(s_tdata);
      if (!s_tvalid || s_tready) begin
        if (pending_values.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= pending_values.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver and checker
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_factors.size() == 0) begin
          report_mismatch($sformatf("factor %0d last %0b with none pending", m_tdata, m_tlast));
        end else begin
          want = expected_factors.pop_front();
          if (m_tdata !== want.factor)
            report_mismatch($sformatf("factor %0d, want %0d", m_tdata, want.factor));
          if (m_tlast !== want.last)
            report_mismatch($sformatf("last %0b on factor %0d, want %0b",
                                      m_tlast, m_tdata, want.last));
        end
      end
      m_tready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Long receiver hold-off during the directed items so the block backs up
  initial begin
    wait (rst_n);
    repeat (50) @(posedge clk);
    hold_off <= 1'b1;
    repeat (SQUEEZE_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    logic [tdf_pkg::VALUE_WIDTH_DEF-1:0] v;
    int unsigned                         counted;

    // zero, one, small primes and composites, squares, powers, all-ones patterns
    pending_values = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd6, 32'd12, 32'd97,
                       32'd65521, 32'd65537, 32'd63001, 32'd131042,
                       32'h8000_0000, 32'hFFFF_FFFF, 32'd3486784401, 32'd223092870,
                       32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_0000, 32'd4294836225,
                       32'd1, 32'd0, 32'd5};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct <= 67; recv_stall_pct <= 0;  end
        2: begin send_idle_pct <= 0;  recv_stall_pct <= 67; end
        default: begin send_idle_pct <= 17; recv_stall_pct <= 17; end
      endcase
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        v = random_value();
        pending_values.push_back(v);
        if (v >= 2) counted++;
      end
      while (pending_values.size() != 0) @(posedge clk);
    end

    while (s_tvalid || expected_factors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("trial_division_factorizer verification clean");
    end else begin
      $display("trial_division_factorizer verification failed");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("trial_division_factorizer verification failed");
    $finish;
  end

endmodule
